/* design/gyro_pointer_tracker_defines.svh */
// assertion macros for the gyro pointer tracker
`ifndef GYRO_POINTER_TRACKER_DEFINES_SVH
`define GYRO_POINTER_TRACKER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define GPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define GPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define GPT_ASSERT_NOW(lbl, ante, cons, msg)
`define GPT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* design/gpt_pkg.sv */
package gpt_pkg;

  localparam int DELTA_W = 16;
  localparam int POS_W = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int RADIUS_W = 16;
  localparam int STEP_W = 8;
  localparam int IDLE_W = 8;
  localparam int COUNT_W = 8;

  localparam int FRAC_BITS_DEFAULT = 8;

  localparam logic [RADIUS_W-1:0] MAX_RADIUS_RESET = 16'd10000;
  localparam logic [STEP_W-1:0] STEP_SIZE_RESET = 8'd10;
  localparam logic [IDLE_W-1:0] IDLE_LIMIT_RESET = 8'd10;

  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_RADIUS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_STEP_SIZE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDLE_LIMIT = 2'd2;

  typedef logic signed [DELTA_W-1:0] delta_t;
  typedef logic signed [POS_W-1:0] pos_t;

endpackage

/* design/gpt_in_if.sv */
interface gpt_in_if;
  logic valid;
  logic ready;
  gpt_pkg::delta_t delta_x;
  gpt_pkg::delta_t delta_y;

  modport source(output valid, output delta_x, output delta_y, input ready);
  modport sink(input valid, input delta_x, input delta_y, output ready);
endinterface

/* design/gpt_out_if.sv */
interface gpt_out_if;
  logic valid;
  logic ready;
  gpt_pkg::pos_t pos_x;
  gpt_pkg::pos_t pos_y;

  modport source(output valid, output pos_x, output pos_y, input ready);
  modport sink(input valid, input pos_x, input pos_y, output ready);
endinterface

/* design/gpt_mul.sv */
module gpt_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  always_ff @(posedge clk) begin
    p <= 64'(a) * 64'(b);
  end

endmodule

/* design/gpt_div.sv */
module gpt_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [63:0]         dividend,
  input  logic [31:0]         divisor,
  input  logic                neg,
  output logic                done,
  output logic signed [31:0]  quotient
);

  localparam int STEPS = 64;
  localparam int CNT_W = $clog2(STEPS);

  logic [31:0]      rem;
  logic [63:0]      quo;
  logic [31:0]      dvs;
  logic             neg_r;
  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [32:0]      shifted;
  logic             fits;
  logic [32:0]      diff;

  assign shifted = {rem, quo[63]};
  assign fits = shifted >= {1'b0, dvs};
  assign diff = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem <= '0;
        quo <= dividend;
        dvs <= divisor;
        neg_r <= neg;
        cnt <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= fits ? diff[31:0] : shifted[31:0];
        quo <= {quo[62:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // magnitude back to signed, saturating
  always_comb begin
    if (neg_r) begin
      if (quo > 64'h0000_0000_8000_0000) quotient = 32'sh8000_0000;
      else quotient = -signed'(quo[31:0]);
    end else begin
      if (|quo[63:31]) quotient = 32'sh7FFF_FFFF;
      else quotient = signed'(quo[31:0]);
    end
  end

endmodule

/* design/gyro_pointer_tracker.sv */
// a result is loaded into the output registers in S_POS, the state after its item is accepted, once the output is free
// a new item is taken only in S_IDLE; when the retreat point stays put or is set, an item first runs S_POS to S_CMP
// a retreat step runs S_RET, S_NEAR on the y axis and S_RET, S_PROD, S_DIVLD, S_DIV, S_NEAR off it,
// waiting in S_DIV for the 64-step serial divider; the shared 32x32 multiplier serves the squares and product
// reset (synchronous): position, retreat point and history to zero,
// max_radius 10000, step_size 10, idle_limit 10
`include "gyro_pointer_tracker_defines.svh"

module gyro_pointer_tracker #(
  parameter int FRAC_BITS = gpt_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  gpt_in_if.sink                           in_ch,
  gpt_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [gpt_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [gpt_pkg::CFG_DATA_W-1:0]   cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_POS, S_SQX, S_SQY, S_SQR, S_CMP, S_RET, S_PROD, S_DIVLD, S_DIV, S_NEAR
  } state_t;

  localparam logic signed [33:0] POS_MAX_EXT = 34'sd2147483647;
  localparam logic signed [33:0] POS_MIN_EXT = -34'sd2147483648;

  function automatic gpt_pkg::pos_t sat34(input logic signed [33:0] v);
    gpt_pkg::pos_t r;
    if (v > POS_MAX_EXT) r = 32'sh7FFF_FFFF;
    else if (v < POS_MIN_EXT) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [31:0] abs32(input gpt_pkg::pos_t v);
    logic [31:0] r;
    r = v[31] ? 32'(-v) : 32'(v);
    return r;
  endfunction

  state_t state;

  logic [gpt_pkg::RADIUS_W-1:0] max_radius;
  logic [gpt_pkg::STEP_W-1:0]   step_size;
  logic [gpt_pkg::IDLE_W-1:0]   idle_limit;

  gpt_pkg::delta_t dx, dy;
  gpt_pkg::pos_t   position_x, position_y, retreat_x, retreat_y, nx;
  gpt_pkg::delta_t bound_delta_x, bound_delta_y, last_delta_x, last_delta_y;
  logic [gpt_pkg::COUNT_W-1:0] repeat_count;
  logic            was_out_of_bound;
  logic            idle;
  logic [63:0]     acc;

  logic            out_valid;
  gpt_pkg::pos_t   out_x, out_y;

  logic [31:0]     s_val, r_val;
  logic signed [33:0] s_ext;
  logic signed [33:0] dx_scaled, dy_scaled;
  gpt_pkg::pos_t   add_x, add_y, new_x, new_y;
  logic            snap, out_free;
  logic [gpt_pkg::COUNT_W-1:0] count_inc;

  logic [31:0]     mul_a, mul_b;
  logic [63:0]     mul_p;
  logic            div_start, div_done, div_neg;
  gpt_pkg::pos_t   div_q;

  assign s_val = 32'(step_size) << FRAC_BITS;
  assign r_val = 32'(max_radius) << FRAC_BITS;
  assign s_ext = signed'(34'(s_val));

  assign dx_scaled = 34'(dx) <<< FRAC_BITS;
  assign dy_scaled = 34'(dy) <<< FRAC_BITS;
  assign add_x = sat34(34'(position_x) + dx_scaled);
  assign add_y = sat34(34'(position_y) + dy_scaled);
  assign snap = was_out_of_bound && (dx != bound_delta_x) && (dy != bound_delta_y);
  assign new_x = snap ? retreat_x : add_x;
  assign new_y = snap ? retreat_y : add_y;
  assign out_free = !out_valid || out_ch.ready;
  assign count_inc = (repeat_count == '1) ? repeat_count : repeat_count + 1'b1;

  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.pos_x = out_x;
  assign out_ch.pos_y = out_y;

  // operand select for the shared multiplier
  always_comb begin
    case (state)
      S_SQX: begin
        mul_a = abs32(position_x);
        mul_b = abs32(position_x);
      end
      S_SQY: begin
        mul_a = abs32(position_y);
        mul_b = abs32(position_y);
      end
      S_SQR: begin
        mul_a = r_val;
        mul_b = r_val;
      end
      S_PROD: begin
        mul_a = abs32(retreat_y);
        mul_b = abs32(nx);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign div_start = (state == S_DIVLD);
  assign div_neg = retreat_y[31] ^ nx[31] ^ retreat_x[31];

  gpt_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  gpt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mul_p),
    .divisor  (abs32(retreat_x)),
    .neg      (div_neg),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      max_radius <= gpt_pkg::MAX_RADIUS_RESET;
      step_size <= gpt_pkg::STEP_SIZE_RESET;
      idle_limit <= gpt_pkg::IDLE_LIMIT_RESET;
      position_x <= '0;
      position_y <= '0;
      retreat_x <= '0;
      retreat_y <= '0;
      bound_delta_x <= '0;
      bound_delta_y <= '0;
      last_delta_x <= '0;
      last_delta_y <= '0;
      repeat_count <= '0;
      was_out_of_bound <= 1'b0;
      idle <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          gpt_pkg::CFG_MAX_RADIUS: max_radius <= cfg_data[gpt_pkg::RADIUS_W-1:0];
          gpt_pkg::CFG_STEP_SIZE:  step_size <= cfg_data[gpt_pkg::STEP_W-1:0];
          gpt_pkg::CFG_IDLE_LIMIT: idle_limit <= cfg_data[gpt_pkg::IDLE_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && out_ch.ready && state != S_POS) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            dx <= in_ch.delta_x;
            dy <= in_ch.delta_y;
            state <= S_POS;
          end
        end
        S_POS: begin
          if (out_free) begin
            position_x <= new_x;
            position_y <= new_y;
            out_x <= new_x;
            out_y <= new_y;
            out_valid <= 1'b1;
            state <= S_SQX;
          end
        end
        S_SQX: state <= S_SQY;
        S_SQY: begin
          acc <= mul_p;
          state <= S_SQR;
        end
        S_SQR: begin
          acc <= acc + mul_p;
          state <= S_CMP;
        end
        S_CMP: begin
          if (acc >= mul_p) begin
            was_out_of_bound <= 1'b1;
            bound_delta_x <= dx;
            bound_delta_y <= dy;
            idle <= 1'b0;
            state <= S_RET;
          end else begin
            was_out_of_bound <= 1'b0;
            if (dx == last_delta_x && dy == last_delta_y) begin
              repeat_count <= count_inc;
              idle <= 1'b1;
              state <= (count_inc > idle_limit) ? S_RET : S_IDLE;
            end else begin
              repeat_count <= '0;
              retreat_x <= position_x;
              retreat_y <= position_y;
              last_delta_x <= dx;
              last_delta_y <= dy;
              state <= S_IDLE;
            end
          end
        end
        S_RET: begin
          if (retreat_x != '0) begin
            nx <= retreat_x[31] ? sat34(34'(retreat_x) + s_ext)
                                : sat34(34'(retreat_x) - s_ext);
            state <= S_PROD;
          end else begin
            if (retreat_y > 0) retreat_y <= sat34(34'(retreat_y) - s_ext);
            else if (retreat_y < 0) retreat_y <= sat34(34'(retreat_y) + s_ext);
            state <= S_NEAR;
          end
        end
        S_PROD: state <= S_DIVLD;
        S_DIVLD: state <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            retreat_y <= div_q;
            retreat_x <= nx;
            state <= S_NEAR;
          end
        end
        S_NEAR: begin
          if (abs32(retreat_x) <= s_val && abs32(retreat_y) <= s_val) begin
            position_x <= '0;
            position_y <= '0;
          end else if (idle) begin
            position_x <= retreat_x;
            position_y <= retreat_y;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `GPT_ASSERT_NEXT(a_accept_to_pos, in_ch.valid && in_ch.ready, state == S_POS, "accepted item did not start the add")
  `GPT_ASSERT_NOW(a_div_done_state, div_done, state == S_DIV, "divider finished outside its wait state")
  `GPT_ASSERT_NOW(a_oob_from_cmp, !$past(rst) && $rose(was_out_of_bound), $past(state) == S_CMP, "out-of-bound flag set outside compare")
  `GPT_ASSERT_NEXT(a_out_load, state == S_POS && out_free, out_valid && out_ch.pos_x == position_x, "result does not match position")

endmodule
